/* src/fcpa_pkg.sv */
// Shared types and constants for the frame cadence phase accumulator.
`timescale 1ns / 1ps

package fcpa_pkg;

    // Field widths
    localparam int PTS_W    = 48;
    localparam int PERIOD_W = 24;
    localparam int WEIGHT_W = 17;
    localparam int ADV_W    = 8;
    localparam int PHASE_W  = 16;
    localparam int CFG_AW   = 3;

    // Serial unit step counts and counter width
    localparam int DIV_STEPS = 24;
    localparam int MAC_STEPS = 17;
    localparam int STEP_CW   = 5;

    // Product register of the serial multiply-accumulate
    localparam int MAC_HI_W   = PERIOD_W + 2;
    localparam int MAC_PROD_W = MAC_HI_W + WEIGHT_W;

    localparam logic [PERIOD_W-1:0] FALLBACK_PERIOD = 24'd384000;
    localparam logic [WEIGHT_W-1:0] ONE_Q16         = 17'h10000;

    // Register reset values
    localparam logic [PERIOD_W-1:0] RST_DISPLAY_PERIOD = 24'd384000;
    localparam logic [PERIOD_W-1:0] RST_INIT_PERIOD    = 24'd384000;
    localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD     = 24'd23040;
    localparam logic [PERIOD_W-1:0] RST_MAX_PERIOD     = 24'd2304000;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT         = 17'd6554;
    localparam logic [ADV_W-1:0]    RST_MAX_ADVANCE    = 8'd2;

    // Item function codes
    localparam logic FUNC_OBSERVE = 1'b0;
    localparam logic FUNC_PRESENT = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_DISPLAY_PERIOD = 3'd0,
        REG_INIT_PERIOD    = 3'd1,
        REG_MIN_PERIOD     = 3'd2,
        REG_MAX_PERIOD     = 3'd3,
        REG_WEIGHT         = 3'd4,
        REG_MAX_ADVANCE    = 3'd5
    } cfg_reg_t;

endpackage

/* src/fcpa_div.sv */
// Restoring divider, one quotient bit per cycle, for display/stream period ratio.
`timescale 1ns / 1ps

module fcpa_div import fcpa_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [PERIOD_W-1:0] dividend,
    input  logic [PERIOD_W-1:0] divisor,
    output logic [PERIOD_W-1:0] quotient,
    output logic                done
);

    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] sh_reg, sh_next;
    logic [PERIOD_W-1:0] dvs_reg;
    logic [STEP_CW-1:0]  cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   trial_diff;
    logic                fits;
    logic                last_step;

    // Dividend is dividend << 16: top 16 bits seed the remainder,
    // the rest enter the shift register and are replaced by quotient bits.
    assign trial      = {rem_reg, sh_reg[PERIOD_W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign fits       = trial >= {1'b0, dvs_reg};
    assign last_step  = cnt_reg == STEP_CW'(DIV_STEPS - 1);

    always_comb begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = {8'd0, dividend[PERIOD_W-1:8]};
            sh_next   = {dividend[7:0], 16'd0};
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            sh_next  = {sh_reg[PERIOD_W-2:0], fits};
            cnt_next = cnt_reg + STEP_CW'(1);
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = sh_reg;
    assign done     = done_reg;

endmodule

/* src/fcpa_mac.sv */
// Bit-serial weighted average: (d*w + avg*(1-w) + half) >> 16.
`timescale 1ns / 1ps

module fcpa_mac import fcpa_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [PERIOD_W-1:0] delta,
    input  logic [PERIOD_W-1:0] average,
    input  logic [WEIGHT_W-1:0] weight,
    output logic [PERIOD_W-1:0] average_new,
    output logic                done
);

    logic [PERIOD_W-1:0]   d_reg;
    logic [PERIOD_W-1:0]   avg_reg;
    logic [WEIGHT_W-1:0]   w_sh_reg, w_sh_next;
    logic [WEIGHT_W-1:0]   wc_sh_reg, wc_sh_next;
    logic [MAC_PROD_W-1:0] prod_reg, prod_next;
    logic [STEP_CW-1:0]    cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [WEIGHT_W-1:0]   w_eff;
    logic [WEIGHT_W-1:0]   w_comp;
    logic [PERIOD_W:0]     addend;
    logic [MAC_HI_W:0]     hi_sum;
    logic [MAC_HI_W+2:0]   rounded;
    logic                  last_step;

    // Weight above one acts as one
    assign w_eff  = (weight > ONE_Q16) ? ONE_Q16 : weight;
    assign w_comp = ONE_Q16 - w_eff;

    // One weight bit of each product per cycle, LSB first, add then shift right
    assign addend = (w_sh_reg[0]  ? {1'b0, d_reg}   : '0)
                  + (wc_sh_reg[0] ? {1'b0, avg_reg} : '0);
    assign hi_sum = {1'b0, prod_reg[MAC_PROD_W-1:WEIGHT_W]} + (MAC_HI_W+1)'(addend);
    assign last_step = cnt_reg == STEP_CW'(MAC_STEPS - 1);

    always_comb begin
        w_sh_next  = w_sh_reg;
        wc_sh_next = wc_sh_reg;
        prod_next  = prod_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            w_sh_next  = w_eff;
            wc_sh_next = w_comp;
            prod_next  = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            w_sh_next  = w_sh_reg >> 1;
            wc_sh_next = wc_sh_reg >> 1;
            prod_next  = {hi_sum, prod_reg[WEIGHT_W-1:1]};
            cnt_next   = cnt_reg + STEP_CW'(1);
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        w_sh_reg  <= w_sh_next;
        wc_sh_reg <= wc_sh_next;
        prod_reg  <= prod_next;
        if (start) begin
            d_reg   <= delta;
            avg_reg <= average;
        end
    end

    // Round to nearest: (prod + 2^15) >> 16
    assign rounded     = {1'b0, prod_reg[MAC_PROD_W-1:15]} + (MAC_HI_W+3)'(1);
    assign average_new = rounded[PERIOD_W:1];
    assign done        = done_reg;

endmodule

/* src/frame_cadence_phase_accumulator.sv */
// Top level: stream period tracking and present-tick phase accumulator.
// Sequence: a timestamp word passes ST_DELTA, then ST_MUL (serial multiply-accumulate)
//   when the average updates, else straight to ST_DONE; a present word passes ST_DIV
//   (serial divider), then ST_DONE, which waits for a free output register.
// One word is in flight at a time: s_ready is high only in ST_IDLE.
// Output register holds a finished word while the next word is accepted.
// Reset (aresetn, synchronous, active low) restores register defaults,
//   clears the timestamp and phase, and loads the average with 384000.
`timescale 1ns / 1ps

module frame_cadence_phase_accumulator import fcpa_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [PTS_W-1:0]    s_frame_pts,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [PTS_W-1:0]    m_previous_pts,
    output logic [ADV_W-1:0]    m_advance_count,
    output logic [PERIOD_W-1:0] m_stream_period
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DELTA = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [PERIOD_W-1:0] disp_period_reg;
    logic [PERIOD_W-1:0] min_period_reg;
    logic [PERIOD_W-1:0] max_period_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [ADV_W-1:0]    max_adv_reg;

    // Block state
    logic [PTS_W-1:0]    last_ts_reg;
    logic [PERIOD_W-1:0] avg_reg;
    logic [PHASE_W-1:0]  phase_reg;

    // Per-word working registers
    logic                func_reg;
    logic [PTS_W-1:0]    pts_reg;
    logic                sat_reg, sat_next;
    logic                upd_reg, upd_next;

    // Output register
    logic                m_valid_reg;
    logic [PTS_W-1:0]    m_prev_reg;
    logic [ADV_W-1:0]    m_adv_reg;
    logic [PERIOD_W-1:0] m_period_reg;

    logic                accept;
    logic                out_free;
    logic                finish;

    logic [PERIOD_W-1:0] disp_eff;
    logic [PERIOD_W-1:0] strm_eff;
    logic                div_start;
    logic [PERIOD_W-1:0] div_quot;
    logic                div_done;

    logic [PTS_W:0]      ts_diff;
    logic                ts_newer;
    logic                big_delta;
    logic [PERIOD_W-1:0] delta_low;
    logic                below_min;
    logic [PERIOD_W-1:0] delta_lo_clamp;
    logic                above_max;
    logic [PERIOD_W-1:0] delta_clamp;
    logic                mac_start;
    logic [PERIOD_W-1:0] mac_avg;
    logic                mac_done;

    logic [PERIOD_W-1:0] ratio;
    logic [PERIOD_W:0]   phase_sum;
    logic [ADV_W:0]      whole;
    logic [ADV_W-1:0]    adv;

    assign s_ready  = state_reg == ST_IDLE;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == ST_DONE) && out_free;

    // Present tick: divisor setup and saturation check (quotient >= 2^24)
    assign disp_eff  = (disp_period_reg == '0) ? FALLBACK_PERIOD : disp_period_reg;
    assign strm_eff  = (avg_reg == '0) ? FALLBACK_PERIOD : avg_reg;
    assign div_start = accept && (s_func == FUNC_PRESENT);

    fcpa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (disp_eff),
        .divisor  (strm_eff),
        .quotient (div_quot),
        .done     (div_done)
    );

    // Timestamp: delta in Q16.8, then clamp (max bound wins when crossed)
    assign ts_diff        = {1'b0, pts_reg} - {1'b0, last_ts_reg};
    assign ts_newer       = (last_ts_reg != '0) && !ts_diff[PTS_W] && (ts_diff[PTS_W-1:0] != '0);
    assign big_delta      = ts_diff[PTS_W-1:16] != '0;
    assign delta_low      = {ts_diff[15:0], 8'd0};
    assign below_min      = !big_delta && (delta_low < min_period_reg);
    assign delta_lo_clamp = below_min ? min_period_reg : delta_low;
    assign above_max      = (big_delta && !below_min) || (delta_lo_clamp > max_period_reg);
    assign delta_clamp    = above_max ? max_period_reg : delta_lo_clamp;
    assign mac_start      = (state_reg == ST_DELTA) && ts_newer;

    fcpa_mac u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (mac_start),
        .delta       (delta_clamp),
        .average     (avg_reg),
        .weight      (weight_reg),
        .average_new (mac_avg),
        .done        (mac_done)
    );

    // Phase update: add ratio, emit clamped whole part, keep fraction
    assign ratio     = sat_reg ? {PERIOD_W{1'b1}} : div_quot;
    assign phase_sum = (PERIOD_W+1)'(phase_reg) + (PERIOD_W+1)'(ratio);
    assign whole     = phase_sum[PERIOD_W:PHASE_W];
    assign adv       = (whole < {1'b0, max_adv_reg}) ? whole[ADV_W-1:0] : max_adv_reg;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        sat_next   = sat_reg;
        upd_next   = upd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    upd_next = 1'b0;
                    sat_next = {8'd0, disp_eff} >= {strm_eff, 8'd0};
                    state_next = (s_func == FUNC_PRESENT) ? ST_DIV : ST_DELTA;
                end
            end
            ST_DELTA: begin
                upd_next   = ts_newer;
                state_next = ts_newer ? ST_MUL : ST_DONE;
            end
            ST_MUL: begin
                if (mac_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sat_reg   <= 1'b0;
            upd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sat_reg   <= sat_next;
            upd_reg   <= upd_next;
        end
    end

    // Input word capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_func;
            pts_reg  <= s_frame_pts;
        end
    end

    // Block state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disp_period_reg <= RST_DISPLAY_PERIOD;
            min_period_reg  <= RST_MIN_PERIOD;
            max_period_reg  <= RST_MAX_PERIOD;
            weight_reg      <= RST_WEIGHT;
            max_adv_reg     <= RST_MAX_ADVANCE;
            last_ts_reg     <= '0;
            avg_reg         <= RST_INIT_PERIOD;
            phase_reg       <= '0;
        end else begin
            if (finish) begin
                if (func_reg == FUNC_PRESENT) begin
                    phase_reg <= phase_sum[PHASE_W-1:0];
                end else begin
                    last_ts_reg <= pts_reg;
                    if (upd_reg) begin
                        avg_reg <= mac_avg;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_DISPLAY_PERIOD: disp_period_reg <= cfg_wdata;
                    REG_INIT_PERIOD:    avg_reg         <= cfg_wdata;
                    REG_MIN_PERIOD:     min_period_reg <= cfg_wdata;
                    REG_MAX_PERIOD:     max_period_reg <= cfg_wdata;
                    REG_WEIGHT:         weight_reg     <= cfg_wdata[WEIGHT_W-1:0];
                    REG_MAX_ADVANCE:    max_adv_reg    <= cfg_wdata[ADV_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            if (func_reg == FUNC_PRESENT) begin
                m_prev_reg   <= '0;
                m_adv_reg    <= adv;
                m_period_reg <= avg_reg;
            end else begin
                m_prev_reg   <= last_ts_reg;
                m_adv_reg    <= '0;
                m_period_reg <= upd_reg ? mac_avg : avg_reg;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_previous_pts  = m_prev_reg;
    assign m_advance_count = m_adv_reg;
    assign m_stream_period = m_period_reg;

endmodule
